FILE: src/gift_pkg.sv
// ----------------------------------------------------------------------------
// gift_pkg
// types, constants and helper functions shared by the round cells and the top
// ----------------------------------------------------------------------------
package gift_pkg;

    localparam int unsigned ROUNDS_DEF = 40;
    localparam int unsigned RC_COUNT   = 40;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = CFG_IDX_W'(1);

    localparam logic [31:0] RC_TOP_BIT = 32'h8000_0000;

    // four 32-bit slices and eight 16-bit key words, index 0 is s0 / w0
    typedef struct packed {
        logic [3:0][31:0] s;
        logic [7:0][15:0] w;
    } t_stage;

    function automatic logic [7:0] round_const(input logic [5:0] idx);
        logic [7:0] rc;
        case (idx)
            6'd0:  rc = 8'h01;  6'd1:  rc = 8'h03;  6'd2:  rc = 8'h07;
            6'd3:  rc = 8'h0F;  6'd4:  rc = 8'h1F;  6'd5:  rc = 8'h3E;
            6'd6:  rc = 8'h3D;  6'd7:  rc = 8'h3B;  6'd8:  rc = 8'h37;
            6'd9:  rc = 8'h2F;  6'd10: rc = 8'h1E;  6'd11: rc = 8'h3C;
            6'd12: rc = 8'h39;  6'd13: rc = 8'h33;  6'd14: rc = 8'h27;
            6'd15: rc = 8'h0E;  6'd16: rc = 8'h1D;  6'd17: rc = 8'h3A;
            6'd18: rc = 8'h35;  6'd19: rc = 8'h2B;  6'd20: rc = 8'h16;
            6'd21: rc = 8'h2C;  6'd22: rc = 8'h18;  6'd23: rc = 8'h30;
            6'd24: rc = 8'h21;  6'd25: rc = 8'h02;  6'd26: rc = 8'h05;
            6'd27: rc = 8'h0B;  6'd28: rc = 8'h17;  6'd29: rc = 8'h2E;
            6'd30: rc = 8'h1C;  6'd31: rc = 8'h38;  6'd32: rc = 8'h31;
            6'd33: rc = 8'h23;  6'd34: rc = 8'h06;  6'd35: rc = 8'h0D;
            6'd36: rc = 8'h1B;  6'd37: rc = 8'h36;  6'd38: rc = 8'h2D;
            6'd39: rc = 8'h1A;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // bit 4i+k of the slice lands on bit i of byte dk
    function automatic logic [31:0] slice_perm(
        input logic [31:0] x,
        input logic [1:0]  d0,
        input logic [1:0]  d1,
        input logic [1:0]  d2,
        input logic [1:0]  d3
    );
        logic [31:0] r;
        int          i;
        r = '0;
        for (i = 0; i < 8; i++) begin
            r[i + 8 * int'(d0)] = x[4 * i + 0];
            r[i + 8 * int'(d1)] = x[4 * i + 1];
            r[i + 8 * int'(d2)] = x[4 * i + 2];
            r[i + 8 * int'(d3)] = x[4 * i + 3];
        end
        return r;
    endfunction

    function automatic logic [15:0] rotr16(input logic [15:0] w, input int unsigned n);
        logic [31:0] d;
        d = {w, w} >> n;
        return d[15:0];
    endfunction

endpackage

FILE: src/gift_round_cell.sv
// ----------------------------------------------------------------------------
// gift_round_cell
// one registered round: s-box, slice permutation, round key, constant, key step
// ----------------------------------------------------------------------------
module gift_round_cell #(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gift_pkg::t_stage i_data,
    output logic            o_valid,
    output gift_pkg::t_stage o_data
);
    import gift_pkg::*;

    localparam logic [5:0] RIDX = 6'(ROUND_IDX);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    always_comb begin
        logic [31:0] s0, s1, s2, s3, t;
        s0 = i_data.s[0];
        s1 = i_data.s[1];
        s2 = i_data.s[2];
        s3 = i_data.s[3];

        // bitsliced s-box
        s1 = s1 ^ (s0 & s2);
        s0 = s0 ^ (s1 & s3);
        s2 = s2 ^ (s0 | s1);
        s3 = s3 ^ s2;
        s1 = s1 ^ s3;
        s3 = ~s3;
        s2 = s2 ^ (s0 & s1);
        t  = s0;
        s0 = s3;
        s3 = t;

        s0 = slice_perm(s0, 2'd0, 2'd3, 2'd2, 2'd1);
        s1 = slice_perm(s1, 2'd1, 2'd0, 2'd3, 2'd2);
        s2 = slice_perm(s2, 2'd2, 2'd1, 2'd0, 2'd3);
        s3 = slice_perm(s3, 2'd3, 2'd2, 2'd1, 2'd0);

        n_data.s[0] = s0;
        n_data.s[1] = s1 ^ {i_data.w[6], i_data.w[7]};
        n_data.s[2] = s2 ^ {i_data.w[2], i_data.w[3]};
        n_data.s[3] = s3 ^ RC_TOP_BIT ^ {24'd0, round_const(RIDX)};

        // key words shift up by two, the top pair rotated
        n_data.w[7] = i_data.w[5];
        n_data.w[6] = i_data.w[4];
        n_data.w[5] = i_data.w[3];
        n_data.w[4] = i_data.w[2];
        n_data.w[3] = i_data.w[1];
        n_data.w[2] = i_data.w[0];
        n_data.w[1] = rotr16(i_data.w[7], 12);
        n_data.w[0] = rotr16(i_data.w[6], 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/gift128_bitsliced_encrypt_top.sv
// ----------------------------------------------------------------------------
// gift128_bitsliced_encrypt_top
// GIFT-128 encryption in bitsliced form, one round cell per round
// ----------------------------------------------------------------------------
// A block is taken on any cycle with i_start high; o_busy never rises, so one
// block can be started every cycle. Each block passes through a chain of
// ROUNDS round cells, one register stage per round, and its ciphertext leaves
// the last cell with o_valid high for one cycle. The receiver cannot stall:
// results must be taken as they come. The key travels with each block, so it
// is sampled at acceptance; write the key registers (index 0 = key_hi,
// 1 = key_lo, others ignored) only while no block is in flight.
module gift128_bitsliced_encrypt_top #(
    parameter int unsigned ROUNDS = gift_pkg::ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [63:0]                    i_block_hi,
    input  logic [63:0]                    i_block_lo,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gift_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output logic                           o_valid,
    output logic [63:0]                    o_cipher_hi,
    output logic [63:0]                    o_cipher_lo
);
    import gift_pkg::*;

    logic [63:0] r_key_hi;
    logic [63:0] r_key_lo;
    logic [63:0] n_key_hi;
    logic [63:0] n_key_lo;

    logic   chain_valid [0:ROUNDS];
    t_stage chain_data  [0:ROUNDS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_key_hi = r_key_hi;
        n_key_lo = r_key_lo;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_HI: n_key_hi = i_cfg_data;
                CFG_KEY_LO: n_key_lo = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else begin
            r_key_hi <= n_key_hi;
            r_key_lo <= n_key_lo;
        end
    end

    // load the item and the current key into the head of the chain
    assign chain_valid[0]     = i_start;
    assign chain_data[0].s[0] = i_block_hi[63:32];
    assign chain_data[0].s[1] = i_block_hi[31:0];
    assign chain_data[0].s[2] = i_block_lo[63:32];
    assign chain_data[0].s[3] = i_block_lo[31:0];
    assign chain_data[0].w[0] = r_key_hi[63:48];
    assign chain_data[0].w[1] = r_key_hi[47:32];
    assign chain_data[0].w[2] = r_key_hi[31:16];
    assign chain_data[0].w[3] = r_key_hi[15:0];
    assign chain_data[0].w[4] = r_key_lo[63:48];
    assign chain_data[0].w[5] = r_key_lo[47:32];
    assign chain_data[0].w[6] = r_key_lo[31:16];
    assign chain_data[0].w[7] = r_key_lo[15:0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        gift_round_cell #(
            .ROUND_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign o_valid     = chain_valid[ROUNDS];
    assign o_cipher_hi = {chain_data[ROUNDS].s[0], chain_data[ROUNDS].s[1]};
    assign o_cipher_lo = {chain_data[ROUNDS].s[2], chain_data[ROUNDS].s[3]};

endmodule
